[design/positional_circular_list_top_defines.svh]
// Assertion macros used by the positional circular list checker.
`ifndef POSITIONAL_CIRCULAR_LIST_TOP_DEFINES_SVH
`define POSITIONAL_CIRCULAR_LIST_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PCL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PCL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/pcl_pkg.sv]
// Types and constants of the positional circular list.
`default_nettype none

package pcl_pkg;

	localparam int OP_W    = 3;
	localparam int VALUE_W = 32;
	localparam int POS_W   = 9;
	localparam int COUNT_W = 9;

	typedef enum logic [OP_W-1:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_END   = 3'd1,
		OP_READ      = 3'd2,
		OP_OVERWRITE = 3'd3,
		OP_REMOVE    = 3'd4
	} pcl_op_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_BADPOS = 2'd1,
		STAT_FULL   = 2'd2
	} pcl_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RM_RD,
		S_RM_WR,
		S_EMIT
	} pcl_state_t;

endpackage

`default_nettype wire

[design/pcl_if.sv]
// Request and response channel interfaces of the positional circular list.
`default_nettype none

interface pcl_in_if import pcl_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           operation;
	logic signed [VALUE_W-1:0] value;
	logic [POS_W-1:0]          position;

	modport source (output valid, output operation, output value, output position,
		input ready);
	modport sink (input valid, input operation, input value, input position,
		output ready);
endinterface

interface pcl_out_if import pcl_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] read_value;
	logic [1:0]                status;
	logic [COUNT_W-1:0]        entry_count;

	modport source (output valid, output read_value, output status, output entry_count,
		input ready);
	modport sink (input valid, input read_value, input status, input entry_count,
		output ready);
endinterface

`default_nettype wire

[design/pcl_slot.sv]
// Shared slot unit: ring-buffer slot of a list offset, modulo the capacity.
`default_nettype none

module pcl_slot import pcl_pkg::*; #(
	parameter int CAPACITY = 256
) (
	input  wire logic [$clog2(CAPACITY)-1:0]   head,
	input  wire logic [$clog2(CAPACITY+1)-1:0] offset,
	output logic [$clog2(CAPACITY)-1:0]        slot
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int LEN_W = $clog2(CAPACITY + 1);
	localparam int SUM_W = LEN_W + 1;

	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] wrapped;

	// Add, then fold back once: correct while head and offset both stay below the capacity
	always_comb begin
		sum = SUM_W'(head) + SUM_W'(offset);
		if (sum >= SUM_W'(CAPACITY)) begin
			wrapped = sum - SUM_W'(CAPACITY);
		end else begin
			wrapped = sum;
		end
		slot = wrapped[IDX_W-1:0];
	end

endmodule

`default_nettype wire

[design/pcl_mem.sv]
// Entry store: one write port and one registered read port.
`default_nettype none

module pcl_mem import pcl_pkg::*; #(
	parameter int DEPTH = 256
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [$clog2(DEPTH)-1:0]      waddr,
	input  wire logic signed [VALUE_W-1:0]     wdata,
	input  wire logic                          re,
	input  wire logic [$clog2(DEPTH)-1:0]      raddr,
	output logic signed [VALUE_W-1:0]          rdata
);

	logic signed [VALUE_W-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; hold the last word when idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[design/positional_circular_list_top.sv]
// Positional circular list: top level with sequencer, list registers and result register.
//
// An ordered list of up to CAPACITY signed 32-bit entries kept in a ring buffer.
// Requests arrive on req (operation, value, position) and each one gives exactly
// one response on rsp (read_value, status, entry_count), in request order.
// Insert front, insert end, read and overwrite make one memory access on transfer,
// then the result register loads from the emit state once it is free.
// Remove at position p of a list of length L closes the gap entry by entry through
// the single read and write port, with one read state and one write state per later entry.
// Failed operations (bad position, full store, unused codes) go straight to the emit state.
// req.ready is high only while the sequencer is idle; one request is in work at a
// time. A finished response waits in the output register, so the next request
// is taken while the previous response is still stalled; the block then holds
// that request's result until rsp.ready frees the register.
// Reset empties the list (head and length to zero) and drops a pending response.
// The store itself is not cleared; only entries inside the list are ever read.
`default_nettype none

module positional_circular_list_top import pcl_pkg::*; #(
	parameter int CAPACITY = 256
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	pcl_in_if.sink     req,
	pcl_out_if.source  rsp
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int LEN_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

	pcl_state_t state_q, state_d;

	logic [IDX_W-1:0] head_q;
	logic [LEN_W-1:0] length_q;
	logic [LEN_W-1:0] cur_q;
	logic [LEN_W-1:0] nxt_q;

	pcl_status_t res_status_q;
	logic        res_read_q;

	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] out_value_q;
	pcl_status_t               out_status_q;
	logic [COUNT_W-1:0]        out_count_q;

	pcl_op_t          op;
	logic [CMP_W-1:0] pos_ext;
	logic [CMP_W-1:0] len_ext;
	logic             pos_ok;
	logic [LEN_W-1:0] pos_off;
	logic             is_full;
	logic             accept;
	logic             emit_free;

	logic [LEN_W-1:0]          slot_off;
	logic [IDX_W-1:0]          slot;
	logic                      mem_we;
	logic                      mem_re;
	logic signed [VALUE_W-1:0] mem_wdata;
	logic signed [VALUE_W-1:0] mem_rdata;

	// Decode the request against the current list
	always_comb begin
		op      = pcl_op_t'(req.operation);
		pos_ext = CMP_W'(req.position);
		len_ext = CMP_W'(length_q);
		pos_ok  = (pos_ext != '0) && (pos_ext <= len_ext);
		pos_off = LEN_W'(pos_ext - CMP_W'(1));
		is_full = (length_q == LEN_W'(CAPACITY));
		accept  = req.valid && req.ready;
		emit_free = !out_valid_q || rsp.ready;
	end

	pcl_slot #(.CAPACITY(CAPACITY)) u_slot (
		.head   (head_q),
		.offset (slot_off),
		.slot   (slot)
	);

	pcl_mem #(.DEPTH(CAPACITY)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (slot),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (slot),
		.rdata (mem_rdata)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					if (op == OP_REMOVE && pos_ok && pos_ext < len_ext) begin
						state_d = S_RM_RD;
					end else begin
						state_d = S_EMIT;
					end
				end
			end
			S_RM_RD: begin
				state_d = S_RM_WR;
			end
			S_RM_WR: begin
				if (nxt_q < length_q) begin
					state_d = S_RM_RD;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (emit_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Sequencer outputs: request ready, slot offset, memory strobes and write data
	always_comb begin
		req.ready = 1'b0;
		slot_off  = '0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_wdata = req.value;
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				case (op)
					OP_INS_FRONT: begin
						slot_off = LEN_W'(CAPACITY - 1);
						mem_we   = req.valid && !is_full;
					end
					OP_INS_END: begin
						slot_off = length_q;
						mem_we   = req.valid && !is_full;
					end
					OP_READ: begin
						slot_off = pos_off;
						mem_re   = req.valid && pos_ok;
					end
					OP_OVERWRITE: begin
						slot_off = pos_off;
						mem_we   = req.valid && pos_ok;
					end
					default: begin
						slot_off = pos_off;
					end
				endcase
			end
			S_RM_RD: begin
				slot_off = nxt_q;
				mem_re   = 1'b1;
			end
			S_RM_WR: begin
				slot_off  = cur_q;
				mem_we    = 1'b1;
				mem_wdata = mem_rdata;
			end
			default: begin
			end
		endcase
	end

	// Sequencer state, list head and length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			length_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				case (op)
					OP_INS_FRONT: begin
						if (!is_full) begin
							head_q   <= slot;
							length_q <= length_q + LEN_W'(1);
						end
					end
					OP_INS_END: begin
						if (!is_full) begin
							length_q <= length_q + LEN_W'(1);
						end
					end
					OP_REMOVE: begin
						if (pos_ok) begin
							length_q <= length_q - LEN_W'(1);
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Shift cursor and pending result
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q      <= pos_off;
			nxt_q      <= LEN_W'(pos_ext);
			res_read_q <= (op == OP_READ) && pos_ok;
			case (op)
				OP_INS_FRONT, OP_INS_END: begin
					res_status_q <= is_full ? STAT_FULL : STAT_OK;
				end
				OP_READ, OP_OVERWRITE, OP_REMOVE: begin
					res_status_q <= pos_ok ? STAT_OK : STAT_BADPOS;
				end
				default: begin
					res_status_q <= STAT_BADPOS;
				end
			endcase
		end else if (state_q == S_RM_WR) begin
			cur_q <= nxt_q;
			nxt_q <= nxt_q + LEN_W'(1);
		end
	end

	// Response valid: set on emit, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && emit_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && emit_free) begin
			out_value_q  <= res_read_q ? mem_rdata : '0;
			out_status_q <= res_status_q;
			out_count_q  <= COUNT_W'(length_q);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.read_value  = out_value_q;
	assign rsp.status      = out_status_q;
	assign rsp.entry_count = out_count_q;

endmodule

`default_nettype wire

[design/pcl_checker.sv]
// Port checker for the positional circular list, bound to the top level.
`default_nettype none
`include "positional_circular_list_top_defines.svh"

module pcl_checker import pcl_pkg::*; (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      req_valid,
	input wire logic                      req_ready,
	input wire logic                      rsp_valid,
	input wire logic                      rsp_ready,
	input wire logic signed [VALUE_W-1:0] rsp_read_value,
	input wire logic [1:0]                rsp_status,
	input wire logic [COUNT_W-1:0]        rsp_entry_count
);

	// A stalled response holds
	`PCL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_value) && $stable(rsp_status) && $stable(rsp_entry_count), "stalled response changed")

	// One request in work at a time
	`PCL_ASSERT_NEXT(a_one_in_work, req_valid && req_ready, !req_ready, "request taken while busy")

	// A new response only comes from work in progress
	`PCL_ASSERT_NOW(a_rsp_from_work, $rose(rsp_valid), $past(!req_ready), "response without work")

	// A failed operation reads nothing
	`PCL_ASSERT_NOW(a_fail_zero, rsp_valid && rsp_status != STAT_OK, rsp_read_value == '0, "failed op returned data")

endmodule

bind positional_circular_list_top pcl_checker u_pcl_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_read_value  (rsp.read_value),
	.rsp_status      (rsp.status),
	.rsp_entry_count (rsp.entry_count)
);

`default_nettype wire

[dv/positional_circular_list_top_tb.sv]
// Self-checking testbench of the positional circular list: directed and random traffic against a list predictor.
`timescale 1ns / 1ps

module positional_circular_list_top_tb;
	import pcl_pkg::*;

	localparam int CAPACITY        = 256;
	localparam int ITEM_TARGET     = 1800;
	localparam int LIMIT_CYCLES    = 4_000_000;
	localparam int TAIL_CYCLES     = 2 * CAPACITY + 16;
	localparam int LONG_HOLD       = 300;
	localparam int OP_FIRST_UNUSED = int'(OP_REMOVE) + 1;
	localparam int OP_LAST_CODE    = (1 << OP_W) - 1;
	localparam int POS_MAX         = (1 << POS_W) - 1;

	typedef struct {
		logic [OP_W-1:0]           op;
		logic signed [VALUE_W-1:0] value;
		logic [POS_W-1:0]          pos;
		bit                        drain_first;
	} list_cmd_t;

	typedef struct {
		logic signed [VALUE_W-1:0] read_value;
		pcl_status_t               status;
		logic [COUNT_W-1:0]        count;
	} list_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pcl_in_if  req_ch ();
	pcl_out_if rsp_ch ();

	positional_circular_list_top #(.CAPACITY(CAPACITY)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// list contents as the block should hold them
	logic signed [VALUE_W-1:0] list_mem [CAPACITY];
	int list_head = 0;
	int list_len = 0;

	list_cmd_t   pending_ops [$];
	list_reply_t expected_replies [$];
	list_cmd_t   offered;

	int plan_len = 0;
	int send_gap = 0;
	int send_calm = 0;
	int rx_gap = 0;
	int rx_calm = 0;
	int rx_hold = 0;
	int replies_seen = 0;
	int cycle_count = 0;
	int mismatch_count = 0;

	always #4 clk = ~clk;

	// Apply one command to the list and return the reply it should give.
	function automatic list_reply_t apply_list_op(list_cmd_t c);
		list_reply_t r;
		bit pos_ok;
		int i;
		r.read_value = '0;
		r.status = STAT_OK;
		pos_ok = (c.pos >= 1) && (int'(c.pos) <= list_len);
		case (c.op)
			OP_INS_FRONT, OP_INS_END: begin
				if (list_len >= CAPACITY) begin
					r.status = STAT_FULL;
				end else if (c.op == OP_INS_FRONT) begin
					list_head = (list_head + CAPACITY - 1) % CAPACITY;
					list_mem[list_head] = c.value;
					list_len++;
				end else begin
					list_mem[(list_head + list_len) % CAPACITY] = c.value;
					list_len++;
				end
			end
			OP_READ: begin
				if (pos_ok)
					r.read_value = list_mem[(list_head + int'(c.pos) - 1) % CAPACITY];
				else
					r.status = STAT_BADPOS;
			end
			OP_OVERWRITE: begin
				if (pos_ok)
					list_mem[(list_head + int'(c.pos) - 1) % CAPACITY] = c.value;
				else
					r.status = STAT_BADPOS;
			end
			OP_REMOVE: begin
				if (pos_ok) begin
					// close the gap: later entries move up one place
					for (i = int'(c.pos) - 1; i + 1 < list_len; i++)
						list_mem[(list_head + i) % CAPACITY] =
							list_mem[(list_head + i + 1) % CAPACITY];
					list_len--;
				end else begin
					r.status = STAT_BADPOS;
				end
			end
			default: r.status = STAT_BADPOS;
		endcase
		r.count = COUNT_W'(list_len);
		return r;
	endfunction

	// Draw an idle gap: mostly none or short, a few long, now and then a calm stretch.
	function automatic int draw_gap(inout int calm_left);
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(99, 0);
		if (r < 2) begin
			calm_left = $urandom_range(120, 30);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// Pick a position: mostly inside the list, sometimes at or past its ends, sometimes anywhere.
	function automatic logic [POS_W-1:0] pick_pos(int len);
		int r;
		r = $urandom_range(99, 0);
		if (r < 75 && len > 0)
			return POS_W'($urandom_range(len, 1));
		if (r < 85)
			return '0;
		if (r < 93)
			return POS_W'(len + 1);
		return POS_W'($urandom_range(POS_MAX, 0));
	endfunction

	function automatic logic [VALUE_W-1:0] draw_value();
		case ($urandom_range(19, 0))
			0: return {1'b1, {(VALUE_W-1){1'b0}}};
			1: return {1'b0, {(VALUE_W-1){1'b1}}};
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Queue a command and track the list length it leaves behind.
	function automatic void queue_op(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
			logic [POS_W-1:0] pos, bit drain_first);
		list_cmd_t c;
		c.op = op;
		c.value = value;
		c.pos = pos;
		c.drain_first = drain_first;
		pending_ops.push_back(c);
		if ((op == OP_INS_FRONT || op == OP_INS_END) && plan_len < CAPACITY)
			plan_len++;
		else if (op == OP_REMOVE && pos >= 1 && int'(pos) <= plan_len)
			plan_len--;
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		mismatch_count++;
	endtask

	// Offer pending commands; predict each one on its transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid     <= 1'b0;
			req_ch.operation <= '0;
			req_ch.value     <= '0;
			req_ch.position  <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				expected_replies.push_back(apply_list_op(offered));
			if (req_ch.valid && !req_ch.ready) begin
				// hold the offered command
			end else if (send_gap > 0) begin
				send_gap--;
				req_ch.valid <= 1'b0;
			end else if (pending_ops.size() > 0 &&
					!(pending_ops[0].drain_first && expected_replies.size() > 0)) begin
				offered = pending_ops.pop_front();
				req_ch.operation <= offered.op;
				req_ch.value     <= offered.value;
				req_ch.position  <= offered.pos;
				req_ch.valid     <= 1'b1;
				send_gap = draw_gap(send_calm);
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Check each reply transfer against the oldest prediction; stall at random.
	always @(posedge clk or negedge arst_n) begin
		list_reply_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_replies.size() == 0) begin
					report_mismatch("reply with nothing expected");
				end else begin
					want = expected_replies.pop_front();
					if (rsp_ch.read_value !== want.read_value)
						report_mismatch($sformatf("reply %0d read_value %0d, expected %0d",
							replies_seen, rsp_ch.read_value, want.read_value));
					if (rsp_ch.status !== want.status)
						report_mismatch($sformatf("reply %0d status %0d, expected %0d",
							replies_seen, rsp_ch.status, want.status));
					if (rsp_ch.entry_count !== want.count)
						report_mismatch($sformatf("reply %0d entry_count %0d, expected %0d",
							replies_seen, rsp_ch.entry_count, want.count));
				end
				replies_seen++;
				// back off for a long stretch so the block fills and stalls its input
				if (replies_seen == 400 || replies_seen == 1500)
					rx_hold = LONG_HOLD;
				rx_gap = draw_gap(rx_calm);
			end
			if (rx_hold > 0) begin
				rx_hold--;
				rsp_ch.ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int r;
		int n;
		int k;
		int fills_done;
		logic [OP_W-1:0] op;
		logic [POS_W-1:0] pos;

		req_ch.valid = 1'b0;
		req_ch.operation = '0;
		req_ch.value = '0;
		req_ch.position = '0;
		rsp_ch.ready = 1'b0;
		fills_done = 0;

		// empty list: every addressed operation is refused
		queue_op(OP_READ, '0, POS_W'(1), 1'b0);
		queue_op(OP_REMOVE, '0, '0, 1'b0);
		queue_op(OP_OVERWRITE, '1, POS_W'(1), 1'b0);
		// both ends with extreme values
		queue_op(OP_INS_END, {1'b0, {(VALUE_W-1){1'b1}}}, '0, 1'b0);
		queue_op(OP_INS_FRONT, {1'b1, {(VALUE_W-1){1'b0}}}, '0, 1'b0);
		queue_op(OP_INS_END, '0, '0, 1'b0);
		queue_op(OP_INS_FRONT, '1, '0, 1'b0);
		queue_op(OP_READ, '0, POS_W'(1), 1'b0);
		queue_op(OP_READ, '0, POS_W'(4), 1'b0);
		queue_op(OP_READ, '0, POS_W'(5), 1'b0);
		queue_op(OP_READ, '0, '0, 1'b0);
		queue_op(OP_READ, '0, POS_W'(POS_MAX), 1'b0);
		queue_op(OP_OVERWRITE, 32'h5555_5555, POS_W'(2), 1'b0);
		queue_op(OP_OVERWRITE, 32'haaaa_aaaa, POS_W'(4), 1'b0);
		queue_op(OP_READ, '0, POS_W'(4), 1'b0);
		// remove in the middle, at the end and at the front
		queue_op(OP_REMOVE, '0, POS_W'(2), 1'b0);
		queue_op(OP_REMOVE, '0, POS_W'(3), 1'b0);
		queue_op(OP_REMOVE, '0, POS_W'(1), 1'b0);
		queue_op(OP_READ, '0, POS_W'(1), 1'b0);
		queue_op(OP_REMOVE, '0, POS_W'(POS_MAX), 1'b0);
		queue_op(OP_OVERWRITE, '1, '0, 1'b0);
		for (k = OP_FIRST_UNUSED; k <= OP_LAST_CODE; k++)
			queue_op(OP_W'(k), '1, POS_W'(1), 1'b0);

		// random episodes, two of them filling the store and draining it again
		while (pending_ops.size() < ITEM_TARGET) begin
			if (fills_done < 2 && pending_ops.size() >= (fills_done == 0 ? 300 : 1000)) begin
				queue_op(OP_READ, '0, pick_pos(plan_len), 1'b1);
				while (plan_len < CAPACITY) begin
					r = $urandom_range(99, 0);
					if (r < 80)
						queue_op(r < 40 ? OP_INS_FRONT : OP_INS_END, draw_value(), '0, 1'b0);
					else
						queue_op(r < 90 ? OP_READ : OP_OVERWRITE, draw_value(),
							pick_pos(plan_len), 1'b0);
				end
				// full store: inserts refused, last place reachable
				for (k = 0; k < 4; k++)
					queue_op(k % 2 ? OP_INS_END : OP_INS_FRONT, draw_value(), '0, 1'b0);
				queue_op(OP_OVERWRITE, draw_value(), POS_W'(CAPACITY), 1'b0);
				queue_op(OP_READ, '0, POS_W'(CAPACITY), 1'b0);
				queue_op(OP_READ, '0, POS_W'(CAPACITY + 1), 1'b0);
				while (plan_len > 0) begin
					if ($urandom_range(99, 0) < 80)
						queue_op(OP_REMOVE, '0, POS_W'($urandom_range(plan_len, 1)), 1'b0);
					else
						queue_op(OP_READ, '0, pick_pos(plan_len), 1'b0);
				end
				fills_done++;
			end else begin
				n = $urandom_range(40, 10);
				for (k = 0; k < n; k++) begin
					r = $urandom_range(99, 0);
					pos = pick_pos(plan_len);
					if (r < 20)
						op = OP_INS_FRONT;
					else if (r < 40)
						op = OP_INS_END;
					else if (r < 62)
						op = OP_READ;
					else if (r < 77)
						op = OP_OVERWRITE;
					else if (r < 95)
						op = OP_REMOVE;
					else
						op = OP_W'($urandom_range(OP_LAST_CODE, OP_FIRST_UNUSED));
					// keep the list short so removals stay cheap
					if ((op == OP_INS_FRONT || op == OP_INS_END) && plan_len > 32 &&
							$urandom_range(1, 0) == 1) begin
						op = OP_REMOVE;
						pos = POS_W'($urandom_range(plan_len, 1));
					end
					queue_op(op, draw_value(), pos, k == 0 && $urandom_range(9, 0) == 0);
				end
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every command to be taken and answered, then let the block settle
		do
			@(negedge clk);
		while (pending_ops.size() != 0 || req_ch.valid || expected_replies.size() != 0);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[files.f]
+incdir+design
design/pcl_pkg.sv
design/pcl_if.sv
design/pcl_slot.sv
design/pcl_mem.sv
design/positional_circular_list_top.sv
design/pcl_checker.sv
dv/positional_circular_list_top_tb.sv
